[rtl/hlps_pkg.sv]
// Shared types, field widths, codes and reset values of the host liveness ping scheduler.
`timescale 1ns / 1ps

package hlps_pkg;

    localparam int TIME_W     = 40;
    localparam int SEQ_W      = 16;
    localparam int HOST_W     = 6;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int ALU_W      = TIME_W + 1;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 64;

    localparam int MAX_HOSTS_DEF = 64;

    localparam logic [CFG_W-1:0] PING_PERIOD_RST  = 32'd360000;
    localparam logic [CFG_W-1:0] QUICK_PERIOD_RST = 32'd5000;
    localparam logic [CFG_W-1:0] DEAD_MARGIN_RST  = 32'd30000;

    localparam logic [CFG_IDX_W-1:0] CFG_PING_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_MARGIN  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPLY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NO_PING   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PING_SENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PING_FAIL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REPLY     = 2'd3;

    // Request to the shared adder/subtractor.
    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    // Result: flag is the borrow of a subtraction or the carry of an addition.
    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             flag;
    } alu_rsp_t;

endpackage

[rtl/hlps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module hlps_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hlps_alu.sv]
// Shared 41-bit adder/subtractor used for every time compare and sum.
`timescale 1ns / 1ps

module hlps_alu (
    input  hlps_pkg::alu_req_t req,
    output hlps_pkg::alu_rsp_t rsp
);

    import hlps_pkg::*;

    logic [ALU_W:0] full;

    always_comb begin
        if (req.sub) begin
            full = {1'b0, req.a} - {1'b0, req.b};
        end else begin
            full = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.sum  = full[ALU_W-1:0];
        rsp.flag = full[ALU_W];
    end

endmodule

[rtl/host_liveness_ping_scheduler_top.sv]
// Top level of the host liveness ping scheduler: sequencer, host flags and stream ports.
// The block keeps a table of up to MAX_HOSTS monitored hosts and decides, on
// each check transaction, whether the earliest due host gets a ping, when it is
// checked next and whether it has gone dead; reply transactions refresh a host
// and load transactions enter one. It takes one input transaction at a time.
// A load is entered from the idle state; a reply reads the stored sequence and
// next check and then compares the sequence. A check scans the table and, when
// a host is due, works through the decision: the scan reads the next-check
// memory one entry per cycle and feeds each value through the single shared
// 41-bit adder/subtractor, which then also works through the ten threshold,
// compare and reschedule steps of the decision one per cycle. A finished result
// sits in the output register until the master side takes it, while the slave
// side already accepts the next transaction; a reply or check that finishes
// while that register is still full waits in S_OUT until it drains. Configuration is written through
// a plain write port and takes effect at once; it must only be written while
// the block is idle. Times are 40-bit millisecond counts and wrap on addition.
`timescale 1ns / 1ps

module host_liveness_ping_scheduler_top #(
    parameter int MAX_HOSTS = hlps_pkg::MAX_HOSTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [hlps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hlps_pkg::CFG_W-1:0]       cfg_wdata,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata, lowest bit up: host[5:0], now_ms[45:6], reply_seq[61:46],
    // send_ok[62], host_active[63], first_check[103:64].
    input  logic [hlps_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: mode[1:0].
    input  logic [hlps_pkg::MODE_W-1:0]      s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata, lowest bit up: out_host[5:0], seq_used[21:6], host_live[22],
    // marked_dead[23], next_due[63:24].
    output logic [hlps_pkg::OUT_DATA_W-1:0]  m_tdata,
    // m_tuser: kind[1:0].
    output logic [hlps_pkg::KIND_W-1:0]      m_tuser
);

    import hlps_pkg::*;

    localparam int IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0]        HOST_CNT = CW'(MAX_HOSTS);
    localparam logic [IW+HOST_W-1:0] HOST_LIM = (IW + HOST_W)'(MAX_HOSTS);

    // One-hot sequencer states.
    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_SCAN   = 16'b0000_0000_0000_0010,
        S_DUE    = 16'b0000_0000_0000_0100,
        S_SINCE  = 16'b0000_0000_0000_1000,
        S_UP     = 16'b0000_0000_0001_0000,
        S_UPCMP  = 16'b0000_0000_0010_0000,
        S_THQ    = 16'b0000_0000_0100_0000,
        S_PCMP   = 16'b0000_0000_1000_0000,
        S_THD    = 16'b0000_0001_0000_0000,
        S_DCMP   = 16'b0000_0010_0000_0000,
        S_THR    = 16'b0000_0100_0000_0000,
        S_RCMP   = 16'b0000_1000_0000_0000,
        S_NEXT   = 16'b0001_0000_0000_0000,
        S_OUT    = 16'b0010_0000_0000_0000,
        S_RFETCH = 16'b0100_0000_0000_0000,
        S_RCHK   = 16'b1000_0000_0000_0000
    } state_t;

    // Input fields.
    logic [HOST_W-1:0]      in_host;
    logic [TIME_W-1:0]      in_now;
    logic [SEQ_W-1:0]       in_rseq;
    logic                   in_send_ok;
    logic                   in_active;
    logic [TIME_W-1:0]      in_first;
    logic [IW+HOST_W-1:0]   in_host_ext;
    logic [IW-1:0]          in_hidx;
    logic                   in_range;

    assign in_host     = s_tdata[5:0];
    assign in_now      = s_tdata[45:6];
    assign in_rseq     = s_tdata[61:46];
    assign in_send_ok  = s_tdata[62];
    assign in_active   = s_tdata[63];
    assign in_first    = s_tdata[103:64];
    assign in_host_ext = {{IW{1'b0}}, in_host};
    assign in_hidx     = in_host_ext[IW-1:0];
    assign in_range    = in_host_ext < HOST_LIM;

    // Control state.
    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   found_reg, found_next;
    logic [MAX_HOSTS-1:0]   active_reg, active_next;
    logic [MAX_HOSTS-1:0]   live_reg, live_next;
    logic [SEQ_W-1:0]       seq_counter_reg, seq_counter_next;
    logic                   in_startup_reg, in_startup_next;
    logic [TIME_W-1:0]      startup_time_reg, startup_time_next;
    logic [CFG_W-1:0]       ping_period_reg, ping_period_next;
    logic [CFG_W-1:0]       quick_period_reg, quick_period_next;
    logic [CFG_W-1:0]       dead_margin_reg, dead_margin_next;
    logic                   m_valid_reg, m_valid_next;

    // Working and payload registers.
    logic [IW-1:0]          hidx_reg, hidx_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [SEQ_W-1:0]       rseq_reg, rseq_next;
    logic                   send_ok_reg, send_ok_next;
    logic [IW-1:0]          rd_idx_reg, rd_idx_next;
    logic [IW-1:0]          sel_reg, sel_next;
    logic [TIME_W-1:0]      best_reg, best_next;
    logic [TIME_W-1:0]      since_reg, since_next;
    logic [TIME_W-1:0]      up_reg, up_next;
    logic [ALU_W-1:0]       tmp_reg, tmp_next;
    logic                   hs_reg, hs_next;
    logic                   do_ping_reg, do_ping_next;
    logic                   dead_c_reg, dead_c_next;
    logic                   quick_c_reg, quick_c_next;
    logic [HOST_W-1:0]      res_host_reg, res_host_next;
    logic [KIND_W-1:0]      res_kind_reg, res_kind_next;
    logic [SEQ_W-1:0]       res_seq_reg, res_seq_next;
    logic                   res_live_reg, res_live_next;
    logic                   res_dead_reg, res_dead_next;
    logic [TIME_W-1:0]      res_due_reg, res_due_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [KIND_W-1:0]      m_tuser_reg, m_tuser_next;

    // Shared unit.
    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;

    // Helpers.
    logic                   was_live;
    logic                   ping_ok;
    logic [IW+HOST_W-1:0]   sel_ext;
    logic [IW+HOST_W-1:0]   rhost_ext;

    // Memory ports.
    logic                   nc_we, nc_re, lr_we, lr_re, lc_we, lc_re, sq_we, sq_re;
    logic [IW-1:0]          nc_waddr, nc_raddr, lr_waddr, lr_raddr;
    logic [IW-1:0]          lc_waddr, lc_raddr, sq_waddr, sq_raddr;
    logic [TIME_W-1:0]      nc_wdata, nc_rdata, lr_wdata, lr_rdata, lc_wdata, lc_rdata;
    logic [SEQ_W-1:0]       sq_wdata, sq_rdata;

    hlps_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Next-check times, read once per entry during a scan.
    hlps_ram #(.WIDTH(TIME_W), .DEPTH(MAX_HOSTS), .AW(IW)) u_due_time (
        .aclk (aclk), .we (nc_we), .waddr (nc_waddr), .wdata (nc_wdata),
        .re (nc_re), .raddr (nc_raddr), .rdata (nc_rdata)
    );

    hlps_ram #(.WIDTH(TIME_W), .DEPTH(MAX_HOSTS), .AW(IW)) u_last_reply (
        .aclk (aclk), .we (lr_we), .waddr (lr_waddr), .wdata (lr_wdata),
        .re (lr_re), .raddr (lr_raddr), .rdata (lr_rdata)
    );

    hlps_ram #(.WIDTH(TIME_W), .DEPTH(MAX_HOSTS), .AW(IW)) u_last_check (
        .aclk (aclk), .we (lc_we), .waddr (lc_waddr), .wdata (lc_wdata),
        .re (lc_re), .raddr (lc_raddr), .rdata (lc_rdata)
    );

    hlps_ram #(.WIDTH(SEQ_W), .DEPTH(MAX_HOSTS), .AW(IW)) u_seq (
        .aclk (aclk), .we (sq_we), .waddr (sq_waddr), .wdata (sq_wdata),
        .re (sq_re), .raddr (sq_raddr), .rdata (sq_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign was_live  = live_reg[sel_reg];
    assign ping_ok   = do_ping_reg && send_ok_reg;
    assign sel_ext   = {{HOST_W{1'b0}}, sel_reg};
    assign rhost_ext = {{HOST_W{1'b0}}, hidx_reg};

    always_comb begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        rd_valid_next     = rd_valid_reg;
        found_next        = found_reg;
        active_next       = active_reg;
        live_next         = live_reg;
        seq_counter_next  = seq_counter_reg;
        in_startup_next   = in_startup_reg;
        startup_time_next = startup_time_reg;
        ping_period_next  = ping_period_reg;
        quick_period_next = quick_period_reg;
        dead_margin_next  = dead_margin_reg;
        m_valid_next      = m_valid_reg;
        hidx_next         = hidx_reg;
        now_next          = now_reg;
        rseq_next         = rseq_reg;
        send_ok_next      = send_ok_reg;
        rd_idx_next       = rd_idx_reg;
        sel_next          = sel_reg;
        best_next         = best_reg;
        since_next        = since_reg;
        up_next           = up_reg;
        tmp_next          = tmp_reg;
        hs_next           = hs_reg;
        do_ping_next      = do_ping_reg;
        dead_c_next       = dead_c_reg;
        quick_c_next      = quick_c_reg;
        res_host_next     = res_host_reg;
        res_kind_next     = res_kind_reg;
        res_seq_next      = res_seq_reg;
        res_live_next     = res_live_reg;
        res_dead_next     = res_dead_reg;
        res_due_next      = res_due_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;

        nc_we = 1'b0; nc_waddr = hidx_reg; nc_wdata = now_reg;
        nc_re = 1'b0; nc_raddr = hidx_reg;
        lr_we = 1'b0; lr_waddr = hidx_reg; lr_wdata = now_reg;
        lr_re = 1'b0; lr_raddr = sel_reg;
        lc_we = 1'b0; lc_waddr = sel_reg;  lc_wdata = now_reg;
        lc_re = 1'b0; lc_raddr = sel_reg;
        sq_we = 1'b0; sq_waddr = sel_reg;  sq_wdata = seq_counter_reg;
        sq_re = 1'b0; sq_raddr = hidx_reg;

        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, now_reg};
        alu_req.b   = {1'b0, best_reg};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PING_PERIOD:  ping_period_next  = cfg_wdata;
                CFG_QUICK_PERIOD: quick_period_next = cfg_wdata;
                CFG_DEAD_MARGIN:  dead_margin_next  = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    hidx_next    = in_hidx;
                    now_next     = in_now;
                    rseq_next    = in_rseq;
                    send_ok_next = in_send_ok;
                    unique case (s_tuser)
                        MODE_CHECK: begin
                            cnt_next      = '0;
                            rd_valid_next = 1'b0;
                            found_next    = 1'b0;
                            state_next    = S_SCAN;
                        end
                        MODE_REPLY: begin
                            if (in_range && active_reg[in_hidx]) begin
                                state_next = S_RFETCH;
                            end
                        end
                        MODE_LOAD: begin
                            if (in_range) begin
                                active_next[in_hidx] = in_active;
                                live_next[in_hidx]   = 1'b0;
                                startup_time_next    = in_now;
                                nc_we = 1'b1; nc_waddr = in_hidx; nc_wdata = in_first;
                                lr_we = 1'b1; lr_waddr = in_hidx; lr_wdata = in_now;
                                lc_we = 1'b1; lc_waddr = in_hidx; lc_wdata = in_now;
                                sq_we = 1'b1; sq_waddr = in_hidx; sq_wdata = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                // Issue one read per cycle; compare the entry read in the cycle before.
                if (cnt_reg < HOST_CNT) begin
                    nc_re         = 1'b1;
                    nc_raddr      = cnt_reg[IW-1:0];
                    rd_valid_next = 1'b1;
                    rd_idx_next   = cnt_reg[IW-1:0];
                    cnt_next      = cnt_reg + CW'(1);
                end else begin
                    rd_valid_next = 1'b0;
                    if (!rd_valid_reg) begin
                        state_next = S_DUE;
                    end
                end
                alu_req.a = {1'b0, nc_rdata};
                alu_req.b = {1'b0, best_reg};
                if (rd_valid_reg && active_reg[rd_idx_reg] && (!found_reg || alu_rsp.flag)) begin
                    best_next  = nc_rdata;
                    sel_next   = rd_idx_reg;
                    found_next = 1'b1;
                end
            end

            S_DUE: begin
                alu_req.a = {1'b0, now_reg};
                alu_req.b = {1'b0, best_reg};
                if (!found_reg || alu_rsp.flag) begin
                    state_next = S_IDLE;
                end else begin
                    lr_re      = 1'b1;
                    lc_re      = 1'b1;
                    state_next = S_SINCE;
                end
            end

            S_SINCE: begin
                alu_req.a  = {1'b0, now_reg};
                alu_req.b  = {1'b0, lr_rdata};
                since_next = alu_rsp.flag ? '0 : alu_rsp.sum[TIME_W-1:0];
                state_next = S_UP;
            end

            S_UP: begin
                alu_req.a  = {1'b0, now_reg};
                alu_req.b  = {1'b0, startup_time_reg};
                up_next    = alu_rsp.flag ? '0 : alu_rsp.sum[TIME_W-1:0];
                state_next = S_UPCMP;
            end

            S_UPCMP: begin
                // A borrow means the time since startup exceeds the ping period.
                alu_req.a       = {{(ALU_W-CFG_W){1'b0}}, ping_period_reg};
                alu_req.b       = {1'b0, up_reg};
                in_startup_next = in_startup_reg && !alu_rsp.flag;
                hs_next         = in_startup_reg && !alu_rsp.flag && !was_live;
                state_next      = S_THQ;
            end

            S_THQ: begin
                alu_req.a  = {{(ALU_W-CFG_W){1'b0}}, ping_period_reg};
                alu_req.b  = {{(ALU_W-CFG_W){1'b0}}, quick_period_reg};
                tmp_next   = alu_rsp.flag ? '0 : alu_rsp.sum;
                state_next = S_PCMP;
            end

            S_PCMP: begin
                alu_req.a    = {1'b0, since_reg};
                alu_req.b    = tmp_reg;
                do_ping_next = hs_reg || !alu_rsp.flag;
                state_next   = S_THD;
            end

            S_THD: begin
                alu_req.sub = 1'b0;
                alu_req.a   = {{(ALU_W-CFG_W){1'b0}}, ping_period_reg};
                alu_req.b   = {{(ALU_W-CFG_W){1'b0}}, dead_margin_reg};
                tmp_next    = alu_rsp.sum;
                state_next  = S_DCMP;
            end

            S_DCMP: begin
                alu_req.a   = {1'b0, since_reg};
                alu_req.b   = tmp_reg;
                dead_c_next = !alu_rsp.flag;
                state_next  = S_THR;
            end

            S_THR: begin
                alu_req.a  = {{(ALU_W-CFG_W){1'b0}}, ping_period_reg};
                alu_req.b  = {{(ALU_W-CFG_W){1'b0}}, dead_margin_reg};
                tmp_next   = alu_rsp.flag ? '0 : alu_rsp.sum;
                state_next = S_RCMP;
            end

            S_RCMP: begin
                alu_req.a    = {1'b0, since_reg};
                alu_req.b    = tmp_reg;
                quick_c_next = !alu_rsp.flag;
                state_next   = S_NEXT;
            end

            S_NEXT: begin
                alu_req.sub = 1'b0;
                priority if (hs_reg) begin
                    alu_req.a = {1'b0, now_reg};
                    alu_req.b = {{(ALU_W-CFG_W){1'b0}}, quick_period_reg};
                end else if (was_live && dead_c_reg) begin
                    alu_req.a = {1'b0, now_reg};
                    alu_req.b = {{(ALU_W-CFG_W){1'b0}}, ping_period_reg};
                end else if (was_live && quick_c_reg) begin
                    alu_req.a = {1'b0, now_reg};
                    alu_req.b = {{(ALU_W-CFG_W){1'b0}}, quick_period_reg};
                end else begin
                    // An accepted ping has just moved the last check to now.
                    alu_req.a = ping_ok ? {1'b0, now_reg} : {1'b0, lc_rdata};
                    alu_req.b = {{(ALU_W-CFG_W){1'b0}}, ping_period_reg};
                end
                nc_we    = 1'b1;
                nc_waddr = sel_reg;
                nc_wdata = alu_rsp.sum[TIME_W-1:0];
                if (ping_ok) begin
                    lc_we = 1'b1;
                    sq_we = 1'b1;
                end
                if (do_ping_reg) begin
                    seq_counter_next = seq_counter_reg + SEQ_W'(1);
                end
                if (was_live && dead_c_reg) begin
                    live_next[sel_reg] = 1'b0;
                end
                res_host_next = sel_ext[HOST_W-1:0];
                res_kind_next = !do_ping_reg ? KIND_NO_PING :
                                (send_ok_reg ? KIND_PING_SENT : KIND_PING_FAIL);
                res_seq_next  = do_ping_reg ? seq_counter_reg : '0;
                res_live_next = was_live && !dead_c_reg;
                res_dead_next = was_live && dead_c_reg;
                res_due_next  = alu_rsp.sum[TIME_W-1:0];
                state_next    = S_OUT;
            end

            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_tdata_next = {res_due_reg, res_dead_reg, res_live_reg,
                                    res_seq_reg, res_host_reg};
                    m_tuser_next = res_kind_reg;
                    state_next   = S_IDLE;
                end
            end

            S_RFETCH: begin
                sq_re      = 1'b1;
                nc_re      = 1'b1;
                state_next = S_RCHK;
            end

            S_RCHK: begin
                if (sq_rdata == rseq_reg) begin
                    lr_we               = 1'b1;
                    live_next[hidx_reg] = 1'b1;
                    // The host index of a reply comes straight from the transaction.
                    res_host_next       = rhost_ext[HOST_W-1:0];
                    res_kind_next       = KIND_REPLY;
                    res_seq_next        = rseq_reg;
                    res_live_next       = 1'b1;
                    res_dead_next       = 1'b0;
                    res_due_next        = nc_rdata;
                    state_next          = S_OUT;
                end else begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            found_reg        <= 1'b0;
            active_reg       <= '0;
            live_reg         <= '0;
            seq_counter_reg  <= '0;
            in_startup_reg   <= 1'b1;
            startup_time_reg <= '0;
            ping_period_reg  <= PING_PERIOD_RST;
            quick_period_reg <= QUICK_PERIOD_RST;
            dead_margin_reg  <= DEAD_MARGIN_RST;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            rd_valid_reg     <= rd_valid_next;
            found_reg        <= found_next;
            active_reg       <= active_next;
            live_reg         <= live_next;
            seq_counter_reg  <= seq_counter_next;
            in_startup_reg   <= in_startup_next;
            startup_time_reg <= startup_time_next;
            ping_period_reg  <= ping_period_next;
            quick_period_reg <= quick_period_next;
            dead_margin_reg  <= dead_margin_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        hidx_reg     <= hidx_next;
        now_reg      <= now_next;
        rseq_reg     <= rseq_next;
        send_ok_reg  <= send_ok_next;
        rd_idx_reg   <= rd_idx_next;
        sel_reg      <= sel_next;
        best_reg     <= best_next;
        since_reg    <= since_next;
        up_reg       <= up_next;
        tmp_reg      <= tmp_next;
        hs_reg       <= hs_next;
        do_ping_reg  <= do_ping_next;
        dead_c_reg   <= dead_c_next;
        quick_c_reg  <= quick_c_next;
        res_host_reg <= res_host_next;
        res_kind_reg <= res_kind_next;
        res_seq_reg  <= res_seq_next;
        res_live_reg <= res_live_next;
        res_dead_reg <= res_dead_next;
        res_due_reg  <= res_due_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // A check transaction always starts a scan, so the slave side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == MODE_CHECK) |=> !s_tready)
        else $error("slave side still ready after a check transaction");

    // The ping sequence only ever steps by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && seq_counter_reg != $past(seq_counter_reg))
            |-> seq_counter_reg == $past(seq_counter_reg) + 16'd1)
        else $error("ping sequence counter jumped");

    // A check without a ping reports sequence zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_NO_PING) |-> m_tdata[21:6] == 16'd0)
        else $error("sequence reported on a check without a ping");

    // A host marked dead is reported as not live and never on a reply.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[23]) |-> (!m_tdata[22] && m_tuser != KIND_REPLY))
        else $error("dead marking inconsistent with live flag or kind");

endmodule

[verif/tb_host_liveness_ping_scheduler_top.sv]
// Self-checking testbench for the host liveness ping scheduler top level.
`timescale 1ns / 1ps

module tb_host_liveness_ping_scheduler_top;
    import hlps_pkg::*;

    // The table depth of the block under test; the prediction tables use the same size.
    localparam int N_HOSTS = MAX_HOSTS_DEF;

    // Mode code that the block must ignore without producing a result.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [CFG_W-1:0]  REG_MAX  = '1;

    // One input transaction, field by field.
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [HOST_W-1:0] host;
        logic [TIME_W-1:0] now_ms;
        logic [SEQ_W-1:0]  reply_seq;
        logic              send_ok;
        logic              host_active;
        logic [TIME_W-1:0] first_check;
    } host_req_t;

    // One result transaction, field by field.
    typedef struct {
        logic [HOST_W-1:0] out_host;
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_used;
        logic              host_live;
        logic              marked_dead;
        logic [TIME_W-1:0] next_due;
    } host_report_t;

    // The scoreboard keeps its own copy of the host table and the timer registers.
    // Every accepted input transaction advances that copy and may queue one
    // expected report; every accepted result is checked against the oldest one.
    class ping_sched_scoreboard;
        logic [CFG_W-1:0]  ping_p;
        logic [CFG_W-1:0]  quick_p;
        logic [CFG_W-1:0]  dead_m;
        logic              active[N_HOSTS];
        logic              live[N_HOSTS];
        logic [TIME_W-1:0] last_reply[N_HOSTS];
        logic [TIME_W-1:0] last_check[N_HOSTS];
        logic [TIME_W-1:0] chk_due[N_HOSTS];
        logic [SEQ_W-1:0]  seq_of[N_HOSTS];
        logic [SEQ_W-1:0]  seq_ctr;
        logic              startup;
        logic [TIME_W-1:0] startup_t;
        host_report_t      due_reports[$];
        int                errors;

        function new();
            ping_p  = PING_PERIOD_RST;
            quick_p = QUICK_PERIOD_RST;
            dead_m  = DEAD_MARGIN_RST;
            for (int i = 0; i < N_HOSTS; i++) begin
                active[i]     = 1'b0;
                live[i]       = 1'b0;
                last_reply[i] = '0;
                last_check[i] = '0;
                chk_due[i]    = '0;
                seq_of[i]     = '0;
            end
            seq_ctr   = '0;
            startup   = 1'b1;
            startup_t = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_PING_PERIOD:  ping_p  = val;
                CFG_QUICK_PERIOD: quick_p = val;
                CFG_DEAD_MARGIN:  dead_m  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function void note_request(host_req_t r);
            host_report_t      rep;
            int                h;
            int                sel;
            logic [TIME_W-1:0] since;
            logic [TIME_W-1:0] up_for;
            logic [CFG_W-1:0]  ping_gap;
            logic [CFG_W-1:0]  warn_gap;
            logic [CFG_W:0]    dead_at;
            logic              was_live;
            logic              host_start;
            logic              do_ping;
            logic              dead;
            h = r.host;
            case (r.mode)
                MODE_LOAD: begin
                    active[h]     = r.host_active;
                    live[h]       = 1'b0;
                    last_reply[h] = r.now_ms;
                    last_check[h] = r.now_ms;
                    chk_due[h]    = r.first_check;
                    seq_of[h]     = '0;
                    startup_t     = r.now_ms;
                end
                MODE_REPLY: begin
                    if (active[h] && seq_of[h] == r.reply_seq) begin
                        last_reply[h]   = r.now_ms;
                        live[h]         = 1'b1;
                        rep.out_host    = r.host;
                        rep.kind        = KIND_REPLY;
                        rep.seq_used    = r.reply_seq;
                        rep.host_live   = 1'b1;
                        rep.marked_dead = 1'b0;
                        rep.next_due    = chk_due[h];
                        due_reports     = {due_reports, rep};
                    end
                end
                MODE_CHECK: begin
                    // Earliest next check among active hosts, lowest index on ties.
                    sel = -1;
                    for (int i = 0; i < N_HOSTS; i++) begin
                        if (active[i] && (sel < 0 || chk_due[i] < chk_due[sel]))
                            sel = i;
                    end
                    if (sel < 0 || chk_due[sel] > r.now_ms)
                        return;
                    // Time differences and register differences saturate at zero.
                    since  = (r.now_ms >= last_reply[sel]) ? r.now_ms - last_reply[sel] : '0;
                    up_for = (r.now_ms >= startup_t) ? r.now_ms - startup_t : '0;
                    if (startup && up_for > TIME_W'(ping_p))
                        startup = 1'b0;
                    ping_gap   = (ping_p >= quick_p) ? ping_p - quick_p : '0;
                    warn_gap   = (ping_p >= dead_m) ? ping_p - dead_m : '0;
                    dead_at    = {1'b0, ping_p} + {1'b0, dead_m};
                    was_live   = live[sel];
                    host_start = startup && !was_live;
                    do_ping    = host_start || since >= TIME_W'(ping_gap);
                    dead       = 1'b0;
                    rep.kind     = KIND_NO_PING;
                    rep.seq_used = '0;
                    if (do_ping) begin
                        rep.seq_used = seq_ctr;
                        if (r.send_ok) begin
                            last_check[sel] = r.now_ms;
                            seq_of[sel]     = seq_ctr;
                            rep.kind        = KIND_PING_SENT;
                        end else begin
                            rep.kind = KIND_PING_FAIL;
                        end
                        seq_ctr = seq_ctr + SEQ_W'(1);
                    end
                    // Rescheduling; all sums wrap at the time width.
                    if (host_start) begin
                        chk_due[sel] = r.now_ms + TIME_W'(quick_p);
                    end else if (was_live && since >= TIME_W'(dead_at)) begin
                        live[sel]    = 1'b0;
                        dead         = 1'b1;
                        chk_due[sel] = r.now_ms + TIME_W'(ping_p);
                    end else if (was_live && since >= TIME_W'(warn_gap)) begin
                        chk_due[sel] = r.now_ms + TIME_W'(quick_p);
                    end else begin
                        chk_due[sel] = last_check[sel] + TIME_W'(ping_p);
                    end
                    rep.out_host    = HOST_W'(sel);
                    rep.host_live   = live[sel];
                    rep.marked_dead = dead;
                    rep.next_due    = chk_due[sel];
                    due_reports     = {due_reports, rep};
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string fname, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [OUT_DATA_W-1:0] td, logic [KIND_W-1:0] tu);
            host_report_t want;
            if (due_reports.size() == 0) begin
                $error("result with nothing expected: out_host %0d, kind %0d", td[5:0], tu);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            cmp_field("out_host", 64'(want.out_host), 64'(td[5:0]));
            cmp_field("kind", 64'(want.kind), 64'(tu));
            cmp_field("seq_used", 64'(want.seq_used), 64'(td[21:6]));
            cmp_field("host_live", 64'(want.host_live), 64'(td[22]));
            cmp_field("marked_dead", 64'(want.marked_dead), 64'(td[23]));
            cmp_field("next_due", 64'(want.next_due), 64'(td[63:24]));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;

    ping_sched_scoreboard sb;

    // Chance in percent that the sender idles or the receiver stalls in a cycle.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // A long receiver hold-off is requested here and counted down by the receiver.
    int hold_request   = 0;
    int hold_left      = 0;
    // Millisecond clock of the well-formed traffic in the current phase.
    logic [TIME_W-1:0] cur_ms = '0;

    // 250 MHz clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    host_liveness_ping_scheduler_top #(
        .MAX_HOSTS(N_HOSTS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Receiver: checks every accepted result transaction and decides the ready
    // level for the next cycle. A requested hold-off keeps ready low for its full
    // count, so the block's output register fills and its input side stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_report(m_tdata, m_tuser);
            if (hold_left == 0 && hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run, so reaching it means a hang.
    initial begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic host_req_t mk_req(logic [MODE_W-1:0] mode, logic [HOST_W-1:0] host,
                                         logic [TIME_W-1:0] now, logic [SEQ_W-1:0] rseq,
                                         logic ok, logic act, logic [TIME_W-1:0] first);
        host_req_t r;
        r.mode        = mode;
        r.host        = host;
        r.now_ms      = now;
        r.reply_seq   = rseq;
        r.send_ok     = ok;
        r.host_active = act;
        r.first_check = first;
        return r;
    endfunction

    // Offers one input transaction, possibly after a random idle gap, and hands it
    // to the scoreboard once it is accepted. Valid stays high from one
    // transaction to the next unless the sender goes idle, so it is never lowered
    // and raised in the same time step. Entered and left at a rising edge.
    task automatic offer_request(input host_req_t r);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.first_check, r.host_active, r.send_ok, r.reply_seq, r.now_ms, r.host};
        s_tuser  <= r.mode;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    // Stops offering and waits until every expected result has arrived. With
    // settle set it then also covers a check that is still scanning without a
    // result to give, so that the block is idle for a register write.
    task automatic wait_quiet(input bit settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        if (settle)
            repeat (N_HOSTS + 40) @(posedge aclk);
    endtask

    // Writes the three timer registers in back-to-back cycles.
    task automatic load_timers(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] q,
                               input logic [CFG_W-1:0] d);
        logic [CFG_IDX_W-1:0] idx[3];
        logic [CFG_W-1:0]     vals[3];
        idx  = '{CFG_PING_PERIOD, CFG_QUICK_PERIOD, CFG_DEAD_MARGIN};
        vals = '{p, q, d};
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Builds one random transaction. Most follow a plausible host life: loads
    // near the running clock, checks as time moves on, and replies that carry
    // the sequence of the outstanding ping. A few are pure noise with every
    // field random, unknown mode included.
    task automatic pick_request(input logic [CFG_W-1:0] span, output host_req_t r);
        int unsigned pick;
        int          tries;
        pick          = $urandom_range(99);
        r.mode        = MODE_CHECK;
        r.host        = HOST_W'($urandom);
        r.now_ms      = TIME_W'({$urandom, $urandom});
        r.reply_seq   = SEQ_W'($urandom);
        r.send_ok     = 1'($urandom);
        r.host_active = 1'($urandom);
        r.first_check = TIME_W'({$urandom, $urandom});
        if (pick < 6) begin
            r.mode = MODE_W'($urandom_range(3));
            return;
        end
        // Advance the clock, now and then far enough for live hosts to go dead.
        cur_ms = cur_ms + TIME_W'($urandom_range(0, span));
        if ($urandom_range(19) == 0)
            cur_ms = cur_ms + TIME_W'(span) * 4;
        r.now_ms = cur_ms;
        if (pick < 12) begin
            r.mode        = MODE_LOAD;
            r.host_active = ($urandom_range(9) != 0);
            r.first_check = cur_ms + TIME_W'($urandom_range(0, span));
        end else if (pick < 60) begin
            r.mode    = MODE_CHECK;
            r.send_ok = ($urandom_range(9) != 0);
        end else begin
            r.mode = MODE_REPLY;
            if ($urandom_range(3) != 0) begin
                tries = 0;
                while (!sb.active[r.host] && tries < 8) begin
                    r.host = HOST_W'($urandom);
                    tries++;
                end
                r.reply_seq = sb.seq_of[r.host];
            end
        end
    endtask

    initial begin
        host_req_t         r;
        logic [CFG_W-1:0]  p;
        logic [CFG_W-1:0]  q;
        logic [CFG_W-1:0]  d;
        logic [CFG_W-1:0]  span;

        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, on the reset timer values. It starts with a check on an
        // empty table and an unknown mode with all fields at their maximum.
        offer_request(mk_req(MODE_CHECK, 0, 0, 0, 1'b1, 1'b0, 0));
        offer_request(mk_req(MODE_SPARE, 63, TIME_MAX, 16'hFFFF, 1'b1, 1'b1, TIME_MAX));
        offer_request(mk_req(MODE_LOAD, 63, 0, 0, 1'b0, 1'b1, 0));
        offer_request(mk_req(MODE_LOAD, 0, 1000, 0, 1'b0, 1'b1, TIME_MAX));
        // A matching reply, a reply with the wrong sequence, one to an idle slot.
        offer_request(mk_req(MODE_REPLY, 63, 500, 0, 1'b0, 1'b0, 0));
        offer_request(mk_req(MODE_REPLY, 63, 600, 16'hFFFF, 1'b0, 1'b0, 0));
        offer_request(mk_req(MODE_REPLY, 1, 600, 0, 1'b0, 1'b0, 0));
        // Check whose time lies before the last reply and the startup time.
        offer_request(mk_req(MODE_CHECK, 0, 200, 0, 1'b1, 1'b0, 0));
        // A host in startup: a refused ping first, then an accepted one.
        offer_request(mk_req(MODE_LOAD, 1, 2000, 0, 1'b0, 1'b1, 1500));
        offer_request(mk_req(MODE_CHECK, 0, 2000, 0, 1'b0, 1'b0, 0));
        offer_request(mk_req(MODE_CHECK, 0, 7000, 0, 1'b1, 1'b0, 0));
        offer_request(mk_req(MODE_REPLY, 1, 7100, sb.seq_of[1], 1'b0, 1'b0, 0));
        // Retire the early hosts so that a host near the top of time is chosen
        // and its reschedule wraps past zero.
        offer_request(mk_req(MODE_LOAD, 63, 7200, 0, 1'b0, 1'b0, 0));
        offer_request(mk_req(MODE_LOAD, 1, 7200, 0, 1'b0, 1'b0, 0));
        offer_request(mk_req(MODE_LOAD, 2, TIME_MAX - 100, 0, 1'b0, 1'b1, TIME_MAX - 50));
        offer_request(mk_req(MODE_CHECK, 0, TIME_MAX, 0, 1'b1, 1'b0, 0));
        offer_request(mk_req(MODE_CHECK, 0, TIME_MAX, 0, 1'b1, 1'b0, 0));
        offer_request(mk_req(MODE_REPLY, 2, 0, sb.seq_of[2], 1'b0, 1'b0, 0));
        offer_request(mk_req(MODE_CHECK, 0, 20000, 0, 1'b0, 1'b0, 0));
        offer_request(mk_req(MODE_SPARE, 0, 0, 0, 1'b0, 1'b0, 0));
        wait_quiet(1'b1);

        // Random part: six phases, each with its own timer setting and idle pattern.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin p = 1000; q = 100; d = 300; end
                1: begin p = '0; q = '0; d = '0; end
                2: begin p = REG_MAX; q = REG_MAX; d = REG_MAX; end
                // Quick period and dead margin above the ping period.
                3: begin p = 500; q = 800; d = 900; end
                4: begin
                    p = $urandom_range(200, 5000);
                    q = $urandom_range(0, 3000);
                    d = $urandom_range(0, 3000);
                end
                default: begin p = $urandom; q = $urandom; d = $urandom; end
            endcase
            load_timers(p, q, d);
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
                default: begin src_idle_pct = 13; sink_stall_pct = 13; end
            endcase
            span   = (p / 3 > 40) ? p / 3 : 40;
            cur_ms = TIME_W'({$urandom, $urandom});
            // The receiver holds off long enough for the input side to back up.
            if (ph == 0)
                hold_request = 3000;
            for (int h = 0; h < 8; h++)
                offer_request(mk_req(MODE_LOAD, HOST_W'(h), cur_ms, SEQ_W'($urandom),
                                     1'($urandom), ($urandom_range(7) != 0),
                                     cur_ms + TIME_W'($urandom_range(0, span))));
            for (int n = 0; n < 300; n++) begin
                // Once, the sender pauses until every expected result is in.
                if (ph == 1 && n == 150)
                    wait_quiet(1'b0);
                pick_request(span, r);
                offer_request(r);
            end
            wait_quiet(1'b1);
        end

        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
